>>> rtl/tbafb_pkg.sv
package tbafb_pkg;

    localparam int SampleBits   = 16;
    localparam int CoefFracBits = 16;
    localparam int NumPhases    = 3;
    localparam int NumSteps     = 4;
    localparam int NumTaps      = 4;
    localparam int HistLen      = 15;
    localparam int WinLen       = HistLen + 1;
    localparam int CoefBits     = CoefFracBits + 2;
    localparam int ProdBits     = SampleBits + CoefBits;
    localparam int FirBits      = ProdBits + 2;
    localparam int FhBits       = FirBits - CoefFracBits;
    localparam int WProdBits    = FirBits + CoefBits;
    localparam int AccBits      = WProdBits + 5;
    localparam int StepCntBits  = 2;
    localparam int NumTapRows   = NumPhases * NumSteps;
    localparam int TapTableBits = NumTapRows * NumTaps * CoefBits;

    typedef logic signed [SampleBits-1:0] t_sample;
    typedef logic signed [CoefBits-1:0]   t_coef;
    typedef logic signed [AccBits-1:0]    t_acc;

    // Weight kinds: zero, plus or minus one, two, or the square root of three.
    typedef enum logic [2:0] {
        W_ZERO, W_P1, W_M1, W_P2, W_M2, W_PR3, W_MR3
    } t_wkind;

    // Taps in units of 1e-8, row k = phase + 3 * step.
    function automatic logic signed [31:0] tap_units(input logic [3:0] k,
                                                     input logic [1:0] t);
        logic signed [31:0] row [0:3];
        begin
            case (k)
                4'd0:  row = '{-32'sd47749, -32'sd496888, 32'sd16547118, 32'sd425496};
                4'd1:  row = '{-32'sd173287, -32'sd1585778, 32'sd14989004, 32'sd994113};
                4'd2:  row = '{-32'sd304815, -32'sd2536082, 32'sd12154542, 32'sd1157993};
                4'd3:  row = '{-32'sd383509, -32'sd2982767, 32'sd8543175, 32'sd983212};
                4'd4:  row = '{-32'sd346946, -32'sd2587886, 32'sd4760441, 32'sd607594};
                4'd5:  row = '{-32'sd154717, -32'sd1136076, 32'sd1387458, 32'sd186353};
                4'd6:  row = '{32'sd186353, 32'sd1387458, -32'sd1136076, -32'sd154717};
                4'd7:  row = '{32'sd607594, 32'sd4760441, -32'sd2587886, -32'sd346946};
                4'd8:  row = '{32'sd983212, 32'sd8543175, -32'sd2982767, -32'sd383509};
                4'd9:  row = '{32'sd1157993, 32'sd12154542, -32'sd2536082, -32'sd304815};
                4'd10: row = '{32'sd994113, 32'sd14989004, -32'sd1585778, -32'sd173287};
                default: row = '{32'sd425496, 32'sd16547118, -32'sd496888, -32'sd47749};
            endcase
            tap_units = row[t];
        end
    endfunction

    // Tap quantized to Q.CoefFracBits, rounded half away from zero.
    function automatic t_coef tap_q(input logic [3:0] k, input logic [1:0] t);
        logic signed [31:0] u;
        longint mag;
        longint q;
        begin
            u   = tap_units(k, t);
            mag = (u < 0) ? -longint'(u) : longint'(u);
            q   = ((mag <<< CoefFracBits) + 64'sd50000000) / 64'sd100000000;
            tap_q = CoefBits'((u < 0) ? -q : q);
        end
    endfunction

    // All quantized taps packed into one constant, entry k * 4 + t.
    function automatic logic [TapTableBits-1:0] build_taps();
        logic [TapTableBits-1:0] v;
        begin
            v = '0;
            for (int k = 0; k < NumTapRows; k++) begin
                for (int t = 0; t < NumTaps; t++)
                    v[(k*NumTaps+t)*CoefBits +: CoefBits] = tap_q(4'(k), 2'(t));
            end
            build_taps = v;
        end
    endfunction

    localparam logic [TapTableBits-1:0] TapTable = build_taps();

    // Square root of three in Q.CoefFracBits, rounded to nearest.
    function automatic t_coef sqrt3_q();
        longint target;
        longint r;
        longint cand;
        begin
            target = 64'sd3 <<< (2 * CoefFracBits);
            r = 0;
            for (int i = CoefFracBits + 1; i >= 0; i--) begin
                cand = r + (64'sd1 <<< i);
                if (cand * cand <= target) r = cand;
            end
            if (target - r * r > r) r = r + 1;
            sqrt3_q = CoefBits'(r);
        end
    endfunction

    localparam t_coef Sqrt3 = sqrt3_q();

    // Modulation weight kind for index m mod 12.
    function automatic t_wkind wkind(input logic [5:0] m);
        logic [5:0] r;
        begin
            r = m;
            if (r >= 6'd48) r = r - 6'd48;
            if (r >= 6'd24) r = r - 6'd24;
            if (r >= 6'd12) r = r - 6'd12;
            case (r)
                6'd0:  wkind = W_P2;
                6'd1:  wkind = W_PR3;
                6'd2:  wkind = W_P1;
                6'd4:  wkind = W_M1;
                6'd5:  wkind = W_MR3;
                6'd6:  wkind = W_M2;
                6'd7:  wkind = W_MR3;
                6'd8:  wkind = W_M1;
                6'd10: wkind = W_P1;
                6'd11: wkind = W_PR3;
                default: wkind = W_ZERO;
            endcase
        end
    endfunction

endpackage

>>> rtl/tbafb_lane.sv
// One phase lane: holds the phase delay line and, per step, forms one sparse
// FIR output with a single multiplier, then weights it into three band
// partials (high and low halves kept apart as in the exact sum).
module tbafb_lane import tbafb_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [1:0]             i_phase,
    input  logic                   i_load,
    input  t_sample                i_sample,
    input  logic                   i_start,
    output logic                   o_done,
    output t_acc                   o_acc [NumPhases],
    input  logic                   i_shift
);

    t_sample r_hist [HistLen];
    t_sample r_cur;
    logic [StepCntBits-1:0] r_step, r_tap;
    logic                   r_busy, r_prod_v, r_fir_v, r_wt_v, r_done;
    logic signed [ProdBits-1:0]  r_prod;
    logic signed [FirBits-1:0]   r_fir;
    logic [StepCntBits-1:0]      r_fstep, r_wstep;
    logic signed [FhBits-1:0]    r_fh;
    logic signed [CoefFracBits:0] r_fl;
    logic [1:0]                  r_band;
    logic                        r_wlast;
    t_acc r_acc [NumPhases];
    logic                        r_wbusy;
    logic [1:0]                  r_ptap, r_pstep;

    t_sample w_tapsmp;
    logic [3:0] w_k, w_kw;
    logic [3:0] w_idx;
    logic [5:0] w_tidx;
    t_coef   w_tap;

    assign w_idx  = {r_tap, r_step};
    assign w_k    = 4'(i_phase) + 4'd3 * 4'(r_step);
    assign w_tidx = {w_k, r_tap};
    assign w_tap  = t_coef'(TapTable[w_tidx*CoefBits +: CoefBits]);

    // Window: delay 0 is the new sample, delays 1..15 the history.
    always_comb begin
        w_tapsmp = r_cur;
        for (int d = 1; d < WinLen; d++) begin
            if (w_idx == 4'(d)) w_tapsmp = r_hist[d-1];
        end
    end

    // Delay line and current sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < HistLen; d++) r_hist[d] <= '0;
            r_cur <= '0;
        end else begin
            if (i_load) r_cur <= i_sample;
            if (i_shift) begin
                r_hist[0] <= r_cur;
                for (int d = 1; d < HistLen; d++) r_hist[d] <= r_hist[d-1];
            end
        end
    end

    // Tap sequencer and multiply-accumulate for the FIR.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_step <= '0; r_tap <= '0;
            r_prod_v <= 1'b0; r_fir_v <= 1'b0;
        end else begin
            r_prod_v <= r_busy;
            r_fir_v  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1; r_step <= '0; r_tap <= '0;
            end else if (r_busy) begin
                r_tap <= r_tap + 1'b1;
                if (r_tap == 2'd3) begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 2'd3) r_busy <= 1'b0;
                end
            end
            if (r_prod_v) begin
                if (r_ptap == 2'd3) r_fir_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= w_tapsmp * w_tap;
        r_ptap  <= r_tap;
        r_pstep <= r_step;
        if (r_prod_v) begin
            if (r_ptap == 2'd0) r_fir <= FirBits'(r_prod);
            else r_fir <= r_fir + FirBits'(r_prod);
            r_fstep <= r_pstep;
        end
    end

    // Weighting: each FIR output is split into floor and remainder parts and
    // folded into the three band partials, one band a cycle.
    t_wkind w_kind;
    logic signed [WProdBits-1:0] w_wh, w_wl;
    logic signed [FhBits+CoefBits-1:0] w_mh, w_ml;
    assign w_kw = 4'(i_phase) + 4'd3 * 4'(r_wstep);
    assign w_kind = wkind(6'(w_kw) * (6'(r_band) * 6'd2 + 6'd1));
    assign w_mh = r_fh * Sqrt3;
    assign w_ml = r_fl * Sqrt3;

    always_comb begin
        case (w_kind)
            W_P1:  begin w_wh = WProdBits'(r_fh) <<< CoefFracBits;
                         w_wl = WProdBits'(r_fl) <<< CoefFracBits; end
            W_M1:  begin w_wh = -(WProdBits'(r_fh) <<< CoefFracBits);
                         w_wl = -(WProdBits'(r_fl) <<< CoefFracBits); end
            W_P2:  begin w_wh = WProdBits'(r_fh) <<< (CoefFracBits + 1);
                         w_wl = WProdBits'(r_fl) <<< (CoefFracBits + 1); end
            W_M2:  begin w_wh = -(WProdBits'(r_fh) <<< (CoefFracBits + 1));
                         w_wl = -(WProdBits'(r_fl) <<< (CoefFracBits + 1)); end
            W_PR3: begin w_wh = WProdBits'(w_mh);
                         w_wl = WProdBits'(w_ml); end
            W_MR3: begin w_wh = -WProdBits'(w_mh);
                         w_wl = -WProdBits'(w_ml); end
            default: begin w_wh = '0; w_wl = '0; end
        endcase
    end

    t_acc r_lo [NumPhases];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wbusy <= 1'b0; r_band <= '0; r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                for (int b = 0; b < NumPhases; b++) begin
                    r_acc[b] <= '0; r_lo[b] <= '0;
                end
            end
            if (r_fir_v) begin
                r_fh    <= FhBits'(r_fir >>> CoefFracBits);
                r_fl    <= {1'b0, r_fir[CoefFracBits-1:0]};
                r_wstep <= r_fstep;
                r_wlast <= (r_fstep == 2'd3);
                r_wbusy <= 1'b1;
                r_band  <= '0;
            end else if (r_wbusy) begin
                r_acc[r_band] <= r_acc[r_band] + AccBits'(w_wh);
                r_lo[r_band]  <= r_lo[r_band] + AccBits'(w_wl);
                r_band <= r_band + 1'b1;
                if (r_band == 2'd2) begin
                    r_wbusy <= 1'b0;
                    r_done  <= r_wlast;
                end
            end
        end
    end

    // Partials handed to the merge: the exact lane sum, scaled by
    // 2^-(2*CoefFracBits). Rounding is left to the merge so that it is done
    // once over all lanes.
    always_comb begin
        for (int b = 0; b < NumPhases; b++)
            o_acc[b] = (r_acc[b] <<< CoefFracBits) + r_lo[b];
    end
    assign o_done = r_done;

    // The delay line only moves once the item's work has finished.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_shift |-> !r_busy)
        else $error("history shifted during FIR");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_fir_v |-> !r_wbusy)
        else $error("weighting overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_start |-> !r_busy && !r_wbusy)
        else $error("lane restarted while busy");

endmodule

>>> rtl/tbafb_merge.sv
// Merge: sums the three exact lane partials per band, rounds once and
// saturates.
module tbafb_merge import tbafb_pkg::*; (
    input  t_acc    i_acc0 [NumPhases],
    input  t_acc    i_acc1 [NumPhases],
    input  t_acc    i_acc2 [NumPhases],
    output t_sample o_band [NumPhases]
);
    localparam logic signed [AccBits+1:0] MaxV = (AccBits+2)'((1 << (SampleBits-1)) - 1);
    localparam logic signed [AccBits+1:0] MinV = -(AccBits+2)'(1 << (SampleBits-1));
    localparam logic signed [AccBits+1:0] Half =
        (AccBits+2)'(64'sd1 <<< (2*CoefFracBits-1));

    logic signed [AccBits+1:0] w_sum, w_y;
    always_comb begin
        for (int b = 0; b < NumPhases; b++) begin
            w_sum = (AccBits+2)'(i_acc0[b]) + (AccBits+2)'(i_acc1[b])
                  + (AccBits+2)'(i_acc2[b]) + Half;
            w_y = w_sum >>> (2*CoefFracBits);
            if (w_y > MaxV) o_band[b] = t_sample'(MaxV);
            else if (w_y < MinV) o_band[b] = t_sample'(MinV);
            else o_band[b] = t_sample'(w_y);
        end
    end
endmodule

>>> rtl/three_band_analysis_filter_bank.sv
// Three-band analysis filter bank. Each input beat carries three fullband
// samples; each output beat carries one rounded, saturated sample of each
// band. Three phase lanes run side by side, each with one shared multiplier
// doing 16 tap products (one per cycle) and a weighting pass; one item is
// processed at a time, and the next beat is taken as soon as the previous
// result sits in the output register, even while that result waits for the
// receiver.
module three_band_analysis_filter_bank import tbafb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // sample_first, sample_second, sample_third
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // band_low, band_mid, band_high
);

    logic r_busy, r_ovalid, r_start;
    logic [47:0] r_odata;
    logic [NumPhases-1:0] w_done;
    t_acc w_acc [NumPhases][NumPhases];
    t_sample w_band [NumPhases];
    logic w_accept, w_finish;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_busy;
    assign w_finish = w_done[0];

    // Phase p takes sample 2-p.
    for (genvar p = 0; p < NumPhases; p++) begin : g_lane
        tbafb_lane u_lane (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_phase(2'(p)),
            .i_load(w_accept),
            .i_sample(s_axis_tdata[(2-p)*SampleBits +: SampleBits]),
            .i_start(r_start), .o_done(w_done[p]), .o_acc(w_acc[p]),
            .i_shift(w_finish)
        );
    end

    tbafb_merge u_merge (.i_acc0(w_acc[0]), .i_acc1(w_acc[1]), .i_acc2(w_acc[2]),
                         .o_band(w_band));

    // Control: busy from accept until the result is registered and the
    // output register is free.
    logic r_hold;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_ovalid <= 1'b0; r_start <= 1'b0; r_hold <= 1'b0;
        end else begin
            r_start <= w_accept;
            if (w_accept) r_busy <= 1'b1;
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (w_finish) r_hold <= 1'b1;
            if ((w_finish || r_hold) && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
                r_odata  <= {w_band[2], w_band[1], w_band[0]};
                r_hold   <= 1'b0;
                r_busy   <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_done[0] |-> w_done[1] && w_done[2])
        else $error("lanes out of step");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_start |-> r_busy)
        else $error("start without busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_finish |-> r_busy)
        else $error("finish while idle");

endmodule

>>> tb/tb_three_band_analysis_filter_bank_checker.sv
`timescale 1ns / 1ps

// Watches both streams of the filter bank, predicts every output beat from
// the accepted input beats and compares each band field by field.
module tb_three_band_analysis_filter_bank_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [47:0] i_in_data,   // sample_first, sample_second, sample_third
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [47:0] i_out_data,  // band_low, band_mid, band_high
    output int          o_fail_count,
    output int          o_pending
);
    import tbafb_pkg::*;

    // Taps in units of 1e-8, row k = phase + 3 * step.
    localparam int TapUnits [0:11][0:3] = '{
        '{-47749, -496888, 16547118, 425496},
        '{-173287, -1585778, 14989004, 994113},
        '{-304815, -2536082, 12154542, 1157993},
        '{-383509, -2982767, 8543175, 983212},
        '{-346946, -2587886, 4760441, 607594},
        '{-154717, -1136076, 1387458, 186353},
        '{186353, 1387458, -1136076, -154717},
        '{607594, 4760441, -2587886, -346946},
        '{983212, 8543175, -2982767, -383509},
        '{1157993, 12154542, -2536082, -304815},
        '{994113, 14989004, -1585778, -173287},
        '{425496, 16547118, -496888, -47749}
    };

    // Weight per modulation index mod 12: 3 stands for the square root of three.
    localparam int WeightKind [0:11] = '{2, 3, 1, 0, -1, -3, -2, -3, -1, 0, 1, 3};

    longint     tap_fixed [0:11][0:3];
    longint     root3_fixed;
    t_sample    band_history [0:NumPhases-1][0:HistLen-1];
    logic [47:0] expected_bands [$];

    // Quantize the taps and the square root of three once at the start.
    initial begin
        longint mag;
        longint target;
        longint r;
        for (int k = 0; k < 12; k++) begin
            for (int t = 0; t < 4; t++) begin
                mag = (TapUnits[k][t] < 0) ? -longint'(TapUnits[k][t])
                                           : longint'(TapUnits[k][t]);
                mag = ((mag <<< CoefFracBits) + 64'sd50000000) / 64'sd100000000;
                tap_fixed[k][t] = (TapUnits[k][t] < 0) ? -mag : mag;
            end
        end
        target = 64'sd3 <<< (2 * CoefFracBits);
        r = 0;
        for (int bitpos = 20; bitpos >= 0; bitpos--) begin
            if ((r + (64'sd1 <<< bitpos)) * (r + (64'sd1 <<< bitpos)) <= target)
                r = r + (64'sd1 <<< bitpos);
        end
        if (target - r * r > r) r = r + 1;
        root3_fixed = r;
    end

    function automatic longint mod_gain(input int m);
        int kind;
        begin
            kind = WeightKind[m % 12];
            if (kind == 3) mod_gain = root3_fixed;
            else if (kind == -3) mod_gain = -root3_fixed;
            else mod_gain = longint'(kind) <<< CoefFracBits;
        end
    endfunction

    // One step of the filter bank: updates the delay lines, returns the bands.
    function automatic logic [47:0] split_bands(input logic [47:0] samples);
        longint acc_hi [0:2];
        longint acc_lo [0:2];
        longint win [0:HistLen];
        longint fir;
        longint fh;
        longint fl;
        longint gain;
        longint total;
        longint y;
        int k;
        logic [47:0] res;
        begin
            for (int b = 0; b < 3; b++) begin
                acc_hi[b] = 0;
                acc_lo[b] = 0;
            end
            for (int p = 0; p < NumPhases; p++) begin
                win[0] = longint'($signed(samples[16*(2-p) +: 16]));
                for (int d = 0; d < HistLen; d++) win[d+1] = longint'(band_history[p][d]);
                for (int s = 0; s < NumSteps; s++) begin
                    k = p + NumPhases * s;
                    fir = 0;
                    for (int t = 0; t < NumTaps; t++)
                        fir += win[NumSteps * t + s] * tap_fixed[k][t];
                    fh = fir >>> CoefFracBits;
                    fl = fir - (fh <<< CoefFracBits);
                    for (int b = 0; b < 3; b++) begin
                        gain = mod_gain(k * (2 * b + 1));
                        acc_hi[b] += fh * gain;
                        acc_lo[b] += fl * gain;
                    end
                end
                for (int d = HistLen - 1; d > 0; d--) band_history[p][d] = band_history[p][d-1];
                band_history[p][0] = t_sample'(win[0]);
            end
            for (int b = 0; b < 3; b++) begin
                total = acc_hi[b] + (acc_lo[b] >>> CoefFracBits);
                y = (total + (64'sd1 <<< (CoefFracBits - 1))) >>> CoefFracBits;
                if (y > 32767) y = 32767;
                if (y < -32768) y = -32768;
                res[16*b +: 16] = y[15:0];
            end
            split_bands = res;
        end
    endfunction

    assign o_pending = expected_bands.size();

    // Predict on each input beat, compare on each output beat.
    always @(posedge i_clk) begin
        logic [47:0] want;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            for (int p = 0; p < NumPhases; p++)
                for (int d = 0; d < HistLen; d++) band_history[p][d] = '0;
            expected_bands.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_bands.size() == 0) begin
                    $display("%0t: unexpected output beat %h", $time, i_out_data);
                    errs++;
                end else begin
                    want = expected_bands.pop_front();
                    for (int b = 0; b < 3; b++) begin
                        if (want[16*b +: 16] !== i_out_data[16*b +: 16]) begin
                            $display("%0t: band %0d expected %0d actual %0d", $time, b,
                                     $signed(want[16*b +: 16]),
                                     $signed(i_out_data[16*b +: 16]));
                            errs++;
                        end
                    end
                end
            end
            if (errs != 0) o_fail_count <= o_fail_count + errs;
            if (i_in_valid && i_in_ready) expected_bands.push_back(split_bands(i_in_data));
        end
    end

endmodule

>>> tb/tb_three_band_analysis_filter_bank.sv
`timescale 1ns / 1ps

module tb_three_band_analysis_filter_bank;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // sample_first, sample_second, sample_third
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // band_low, band_mid, band_high
    int          fail_count;
    int          pending;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          beats_sent;
    bit          long_hold_done;
    int          hold_left;

    three_band_analysis_filter_bank u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    tb_three_band_analysis_filter_bank_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #8ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off midway through the run.
    initial begin
        m_axis_tready = 1'b0;
        long_hold_done = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && beats_sent >= 500) begin
                long_hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one beat, with random idle cycles ahead of it. The ready level is
    // taken at the clock edge itself, before the block updates it.
    task automatic send_samples(input logic [47:0] samples);
        begin
            while ($urandom_range(99) < tx_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= samples;
            @(posedge i_clk iff s_axis_tready);
            beats_sent++;
        end
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(5))
            0: pick_sample = 16'h7fff;
            1: pick_sample = 16'h8000;
            2: pick_sample = 16'($signed($urandom_range(255)) - 128);
            default: pick_sample = 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [47:0] samples;
        int run_len;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_rst_n       = 1'b0;
        beats_sent    = 0;
        tx_idle_pct   = 9;
        rx_idle_pct   = 48;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zeros, impulses on each input position, full-scale runs.
        send_samples('0);
        for (int pos = 0; pos < 3; pos++) begin
            samples = '0;
            samples[16*pos +: 16] = 16'h7fff;
            send_samples(samples);
            samples[16*pos +: 16] = 16'h8000;
            send_samples(samples);
        end
        repeat (6) send_samples({3{16'h7fff}});
        repeat (6) send_samples({3{16'h8000}});
        // Alternating signs push the high band toward saturation.
        for (int i = 0; i < 6; i++)
            send_samples((i % 2) ? {16'h7fff, 16'h8000, 16'h7fff}
                                 : {16'h8000, 16'h7fff, 16'h8000});

        // Random: three idling profiles, with a settle pause in the middle.
        for (int phase_no = 0; phase_no < 3; phase_no++) begin
            tx_idle_pct = (phase_no == 0) ? 9 : (phase_no == 1) ? 48 : 0;
            rx_idle_pct = (phase_no == 0) ? 48 : (phase_no == 1) ? 9 : 0;
            for (int i = 0; i < 350; i += run_len) begin
                run_len = $urandom_range(1, 12);
                // Runs of full-scale or random content.
                for (int j = 0; j < run_len; j++)
                    send_samples({pick_sample(), pick_sample(), pick_sample()});
                if (phase_no == 1 && i < 12) begin
                    s_axis_tvalid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
